FILE: rtl/pmc_pkg.sv
// Package for the PS/2 mouse packet cursor block.
// Holds the shared packet type, register indexes and default sizes.
// No dependencies.
package pmc_pkg;

	localparam int MAX_DELTA_DEFAULT  = 32;
	localparam int COORD_BITS_DEFAULT = 12;

	localparam int BYTE_BITS  = 8;
	localparam int BTN_BITS   = 3;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BYTE_BITS-1:0] SYNC_MASK = 8'h08;
	localparam logic [BYTE_BITS-1:0] OVF_MASK  = 8'hC0;

	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 768;
	localparam int RESET_POS_X  = 512;
	localparam int RESET_POS_Y  = 384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1
	} pmc_reg_t;

	// One complete packet that passed the overflow check.
	typedef struct packed {
		logic [BTN_BITS-1:0]  buttons;
		logic [BYTE_BITS-1:0] x_byte;
		logic [BYTE_BITS-1:0] y_byte;
	} pmc_packet_t;

endpackage

FILE: rtl/pmc_assembler.sv
// Byte framer: collects header, X and Y bytes into one packet register.
// Depends on pmc_pkg.
module pmc_assembler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	input  logic [pmc_pkg::BYTE_BITS-1:0]  byte_data,
	input  logic                           pkt_take,
	output logic                           pkt_valid,
	output pmc_pkg::pmc_packet_t           pkt
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_X,
		PH_Y
	} phase_t;

	phase_t                        phase_q;
	logic [pmc_pkg::BYTE_BITS-1:0] header_q;
	logic [pmc_pkg::BYTE_BITS-1:0] x_byte_q;
	logic                          pkt_valid_s1;
	pmc_pkg::pmc_packet_t          pkt_s1;
	logic                          hdr_ovf;
	logic                          pkt_load;

	assign hdr_ovf   = |(header_q & pmc_pkg::OVF_MASK);
	// Packets with an overflow flag produce no item.
	assign pkt_load  = byte_valid && (phase_q == PH_Y) && !hdr_ovf;
	assign pkt_valid = pkt_valid_s1;
	assign pkt       = pkt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			pkt_valid_s1 <= 1'b0;
		end else begin
			if (pkt_load)
				pkt_valid_s1 <= 1'b1;
			else if (pkt_take)
				pkt_valid_s1 <= 1'b0;
			if (byte_valid) begin
				case (phase_q)
					PH_X: begin
						phase_q <= PH_Y;
					end
					PH_Y: begin
						phase_q <= PH_HEADER;
					end
					default: begin
						if (|(byte_data & pmc_pkg::SYNC_MASK))
							phase_q <= PH_X;
						else
							phase_q <= PH_HEADER;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid) begin
			case (phase_q)
				PH_X: begin
					x_byte_q <= byte_data;
				end
				PH_Y: begin
					pkt_s1.buttons <= header_q[pmc_pkg::BTN_BITS-1:0];
					pkt_s1.x_byte  <= x_byte_q;
					pkt_s1.y_byte  <= byte_data;
				end
				default: begin
					header_q <= byte_data;
				end
			endcase
		end
	end

endmodule

FILE: rtl/pmc_cursor.sv
// Cursor update: saturates the deltas, moves and clamps the cursor, and
// holds the result register. Depends on pmc_pkg.
module pmc_cursor #(
	parameter int MAX_DELTA  = pmc_pkg::MAX_DELTA_DEFAULT,
	parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pkt_valid,
	input  pmc_pkg::pmc_packet_t           pkt,
	input  logic [COORD_BITS:0]            bound_x,
	input  logic [COORD_BITS:0]            bound_y,
	output logic                           pkt_take,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [COORD_BITS-1:0]          cursor_x,
	output logic [COORD_BITS-1:0]          cursor_y,
	output logic [pmc_pkg::BTN_BITS-1:0]   buttons
);

	localparam int SUM_W = COORD_BITS + 2;
	localparam logic signed [7:0] DMAX = 8'(MAX_DELTA);
	localparam logic signed [7:0] DMIN = -8'(MAX_DELTA);
	localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(pmc_pkg::RESET_POS_X);
	localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(pmc_pkg::RESET_POS_Y);

	logic [COORD_BITS-1:0]        pos_x_q, pos_y_q;
	logic                         out_valid_q;
	logic [COORD_BITS-1:0]        out_x_q, out_y_q;
	logic [pmc_pkg::BTN_BITS-1:0] out_btn_q;
	logic signed [7:0]            dx_raw, dy_raw, dx, dy;
	logic signed [SUM_W-1:0]      sum_x, sum_y;
	logic [COORD_BITS-1:0]        next_x, next_y;

	assign dx_raw = pkt.x_byte;
	assign dy_raw = pkt.y_byte;

	always_comb begin
		if (dx_raw > DMAX)
			dx = DMAX;
		else if (dx_raw < DMIN)
			dx = DMIN;
		else
			dx = dx_raw;
		if (dy_raw > DMAX)
			dy = DMAX;
		else if (dy_raw < DMIN)
			dy = DMIN;
		else
			dy = dy_raw;
	end

	// Screen y grows downward, so the mouse y delta is subtracted.
	assign sum_x = $signed({2'b00, pos_x_q}) + SUM_W'(dx);
	assign sum_y = $signed({2'b00, pos_y_q}) - SUM_W'(dy);

	always_comb begin
		if (sum_x < 0)
			next_x = '0;
		else if (sum_x >= $signed({1'b0, bound_x}))
			next_x = COORD_BITS'(bound_x - 1'b1);
		else
			next_x = sum_x[COORD_BITS-1:0];
		if (sum_y < 0)
			next_y = '0;
		else if (sum_y >= $signed({1'b0, bound_y}))
			next_y = COORD_BITS'(bound_y - 1'b1);
		else
			next_y = sum_y[COORD_BITS-1:0];
	end

	assign pkt_take  = pkt_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cursor_x  = out_x_q;
	assign cursor_y  = out_y_q;
	assign buttons   = out_btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= POS_X_RST;
			pos_y_q     <= POS_Y_RST;
		end else begin
			if (pkt_take) begin
				out_valid_q <= 1'b1;
				pos_x_q     <= next_x;
				pos_y_q     <= next_y;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			out_x_q   <= next_x;
			out_y_q   <= next_y;
			out_btn_q <= pkt.buttons;
		end
	end

endmodule

FILE: rtl/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet cursor: bound registers, framer and
// cursor update. Depends on pmc_pkg, pmc_assembler and pmc_cursor.
//
//  Channel | Direction | Handshake          | Carries
//  s_*     | in        | s_tvalid/s_tready  | one mouse byte per item
//  m_*     | out       | m_tvalid/m_tready  | cursor position and buttons
//  cfg_*   | in        | cfg_valid/cfg_ready| bound register writes
//
// One byte is taken per cycle while s_tready is high. The third byte of a good
// packet is stored in the packet register and then in the result register,
// which presents it as an item. Reset puts the cursor at 512,384 and the
// bounds at 1024 by 768. A stalled output holds one item in the result
// register and one in the packet register before s_tready drops.
module ps2_mouse_packet_cursor #(
	parameter int MAX_DELTA  = pmc_pkg::MAX_DELTA_DEFAULT,
	parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEFAULT,
	localparam int OUT_W = ((2 * COORD_BITS + pmc_pkg::BTN_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cursor_x, cursor_y, btn_left, btn_right, btn_middle, zero fill
	output logic [OUT_W-1:0]                m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LIMIT = 2 ** COORD_BITS;
	localparam logic [COORD_BITS:0] W_RST = (COORD_BITS+1)'(
		(pmc_pkg::RESET_WIDTH > LIMIT) ? LIMIT : pmc_pkg::RESET_WIDTH);
	localparam logic [COORD_BITS:0] H_RST = (COORD_BITS+1)'(
		(pmc_pkg::RESET_HEIGHT > LIMIT) ? LIMIT : pmc_pkg::RESET_HEIGHT);

	logic [COORD_BITS:0]          bound_x_q, bound_y_q;
	logic [COORD_BITS:0]          cfg_bound;
	logic                         pkt_valid, pkt_take, in_accept;
	pmc_pkg::pmc_packet_t         pkt;
	logic [COORD_BITS-1:0]        cursor_x, cursor_y;
	logic [pmc_pkg::BTN_BITS-1:0] buttons;

	assign cfg_ready = 1'b1;
	// Bounds above the coordinate range act as the full range.
	assign cfg_bound = (int'(cfg_data) > LIMIT) ? (COORD_BITS+1)'(LIMIT)
	                                            : (COORD_BITS+1)'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_x_q <= W_RST;
			bound_y_q <= H_RST;
		end else if (cfg_valid && cfg_data != '0) begin
			case (cfg_index)
				pmc_pkg::REG_SCREEN_WIDTH:  bound_x_q <= cfg_bound;
				pmc_pkg::REG_SCREEN_HEIGHT: bound_y_q <= cfg_bound;
				default: ;
			endcase
		end
	end

	assign s_tready  = !pkt_valid || pkt_take;
	assign in_accept = s_tvalid && s_tready;

	pmc_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_accept),
		.byte_data  (s_tdata),
		.pkt_take   (pkt_take),
		.pkt_valid  (pkt_valid),
		.pkt        (pkt)
	);

	pmc_cursor #(
		.MAX_DELTA  (MAX_DELTA),
		.COORD_BITS (COORD_BITS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.bound_x   (bound_x_q),
		.bound_y   (bound_y_q),
		.pkt_take  (pkt_take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cursor_x  (cursor_x),
		.cursor_y  (cursor_y),
		.buttons   (buttons)
	);

	assign m_tdata = OUT_W'({buttons, cursor_y, cursor_x});

endmodule
